FILE: sv/cle_pkg.sv
package cle_pkg;

   // Character codes used by the escaper
   localparam logic [7:0] BSL_CHAR = 8'h5C;
   localparam logic [7:0] DQ_CHAR  = 8'h22;
   localparam logic [7:0] SQ_CHAR  = 8'h27;
   localparam logic [7:0] NUL_CHAR = 8'h00;

   // Most output beats one input beat can expand to
   localparam int MAX_BEATS = 5;
   localparam int COUNT_W   = $clog2(MAX_BEATS + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       escape_error;
   } rsp_type;

   // One classified input beat: the bytes it expands to and their count
   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] bytes;
      logic [COUNT_W-1:0]        count;
      logic                      last;
      logic                      err;
   } cmd_type;

endpackage

FILE: sv/cle_front.sv
module cle_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write,
   input  logic            csr_wdata,
   input  logic            accept,
   input  cle_pkg::req_type req,
   output logic            push,
   output cle_pkg::cmd_type cmd
);
   import cle_pkg::*;

   typedef enum logic [2:0] {
      CTX_PLAIN   = 3'd0,
      CTX_ESC     = 3'd1,
      CTX_STR     = 3'd2,
      CTX_STR_ESC = 3'd3,
      CTX_CHR     = 3'd4,
      CTX_CHR_ESC = 3'd5,
      CTX_CLOSE   = 3'd6
   } ctx_type;

   ctx_type    ctx_ff, ctx_in;
   logic       start_ff, start_in;
   logic       wrap_ff;

   logic [7:0] c;
   logic [7:0] letter;
   logic       last;
   logic       use_plain;
   logic       err;
   logic [3:0][7:0] b;
   logic [2:0] bc;
   logic       pre, post;
   logic [COUNT_W-1:0] sum;
   logic [2:0] idx;

   // Letter for a control byte that has a backslash form, else zero
   function automatic logic [7:0] ctl_letter(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'd7:    r = "a";
         8'd8:    r = "b";
         8'd12:   r = "f";
         8'd10:   r = "n";
         8'd13:   r = "r";
         8'd9:    r = "t";
         8'd11:   r = "v";
         default: r = NUL_CHAR;
      endcase
      return r;
   endfunction

   function automatic logic is_simple(input logic [7:0] x);
      return x == "a" || x == "b" || x == "f" || x == "n" || x == "r" ||
             x == "t" || x == "v" || x == SQ_CHAR || x == "?";
   endfunction

   assign c      = req.in_byte;
   assign last   = req.in_last;
   assign letter = ctl_letter(c);

   // Classify the byte against the current context
   always_comb begin
      b         = {4{DQ_CHAR}};
      bc        = 3'd0;
      ctx_in    = CTX_PLAIN;
      err       = 1'b0;
      use_plain = 1'b0;
      unique case (ctx_ff)
         CTX_ESC: begin
            if (is_simple(c)) begin
               b[0] = BSL_CHAR; b[1] = BSL_CHAR; b[2] = c; bc = 3'd3;
            end else if (c == DQ_CHAR) begin
               b[0] = BSL_CHAR; b[1] = BSL_CHAR; b[2] = BSL_CHAR; b[3] = DQ_CHAR;
               bc = 3'd4;
            end else if (c == BSL_CHAR) begin
               b = {4{BSL_CHAR}}; bc = 3'd4;
            end else begin
               b[0] = c; bc = 3'd1;
            end
         end
         CTX_STR: begin
            ctx_in = CTX_STR;
            if (letter != NUL_CHAR) begin
               b[0] = BSL_CHAR; b[1] = letter; bc = 3'd2;
            end else if (c == BSL_CHAR) begin
               if (last) err = 1'b1;
               else ctx_in = CTX_STR_ESC;
            end else if (c == DQ_CHAR) begin
               b[0] = BSL_CHAR; b[1] = DQ_CHAR; bc = 3'd2;
               ctx_in = CTX_PLAIN;
            end else begin
               b[0] = c; bc = 3'd1;
            end
         end
         CTX_STR_ESC: begin
            ctx_in = CTX_STR;
            b[0] = BSL_CHAR; b[1] = BSL_CHAR;
            if (is_simple(c)) begin
               b[2] = BSL_CHAR; b[3] = c; bc = 3'd4;
            end else if (c == DQ_CHAR) begin
               b[2] = BSL_CHAR; b[3] = DQ_CHAR; bc = 3'd4;
            end else if (c == BSL_CHAR) begin
               b[2] = BSL_CHAR; b[3] = BSL_CHAR; bc = 3'd4;
            end else begin
               b[2] = c; bc = 3'd3;
            end
         end
         CTX_CHR: begin
            ctx_in = CTX_CLOSE;
            if (c == BSL_CHAR) begin
               if (last) begin
                  b[0] = BSL_CHAR; b[1] = BSL_CHAR; bc = 3'd2;
               end else begin
                  ctx_in = CTX_CHR_ESC;
               end
            end else if (c == DQ_CHAR || c == SQ_CHAR) begin
               b[0] = BSL_CHAR; b[1] = c; bc = 3'd2;
            end else begin
               b[0] = c; bc = 3'd1;
            end
         end
         CTX_CHR_ESC: begin
            ctx_in = CTX_CLOSE;
            if (c == BSL_CHAR) begin
               b = {4{BSL_CHAR}}; bc = 3'd4;
            end else if (c == DQ_CHAR) begin
               b[0] = BSL_CHAR; b[1] = DQ_CHAR; bc = 3'd2;
            end else begin
               b[0] = BSL_CHAR; b[1] = BSL_CHAR; b[2] = c; bc = 3'd3;
            end
         end
         CTX_CLOSE: begin
            if (c == SQ_CHAR) begin
               b[0] = SQ_CHAR; bc = 3'd1;
            end else begin
               use_plain = 1'b1;
            end
         end
         default: use_plain = 1'b1;
      endcase

      // Plain text handling, also for a non-quote byte awaiting the close
      if (use_plain) begin
         ctx_in = CTX_PLAIN;
         if (letter != NUL_CHAR) begin
            b[0] = BSL_CHAR; b[1] = letter; bc = 3'd2;
         end else if (c == BSL_CHAR) begin
            if (last) begin
               b[0] = BSL_CHAR; b[1] = BSL_CHAR; bc = 3'd2;
            end else begin
               ctx_in = CTX_ESC;
            end
         end else if (c == DQ_CHAR) begin
            b[0] = BSL_CHAR; b[1] = DQ_CHAR; bc = 3'd2;
            ctx_in = CTX_STR;
         end else if (c == SQ_CHAR) begin
            b[0] = SQ_CHAR; bc = 3'd1;
            ctx_in = CTX_CHR;
         end else begin
            b[0] = c; bc = 3'd1;
         end
      end

      // End of text or an error returns to plain text at a new start
      if (last || err) ctx_in = CTX_PLAIN;
      start_in = last || err;
   end

   // Frame the body with the wrap quotes and cap the beat count; an error gives one NUL beat
   always_comb begin
      pre  = start_ff && wrap_ff;
      post = last && wrap_ff;
      sum  = COUNT_W'({2'b0, pre}) + COUNT_W'(bc) + COUNT_W'({2'b0, post});
      cmd.count = (sum > COUNT_W'(MAX_BEATS)) ? COUNT_W'(MAX_BEATS) : sum;
      cmd.last  = last;
      cmd.err   = err;
      for (int k = 0; k < MAX_BEATS; k++) begin
         idx = 3'(k) - {2'b0, pre};
         if (k == 0 && pre) cmd.bytes[k] = DQ_CHAR;
         else if (idx < bc) cmd.bytes[k] = b[idx[1:0]];
         else cmd.bytes[k] = DQ_CHAR;
      end
      if (err) begin
         cmd.bytes    = '0;
         cmd.bytes[0] = NUL_CHAR;
         cmd.count    = COUNT_W'(1);
      end
   end

   // Skip beats that expand to nothing
   assign push = accept && (cmd.count != '0);

   // Hold context, text start and the wrap setting
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff   <= CTX_PLAIN;
         start_ff <= 1'b1;
         wrap_ff  <= 1'b1;
      end else begin
         if (csr_write) wrap_ff <= csr_wdata;
         if (accept) begin
            ctx_ff   <= ctx_in;
            start_ff <= start_in;
         end
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req.in_last |=> start_ff && ctx_ff == CTX_PLAIN)
      else $error("text end did not return to plain text start");

endmodule

FILE: sv/cle_queue.sv
module cle_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cle_pkg::cmd_type push_data,
   input  logic             pop,
   output cle_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import cle_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("push into a full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty command queue");

endmodule

FILE: sv/cle_back.sv
module cle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  cle_pkg::cmd_type head,
   output logic             head_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output cle_pkg::rsp_type rsp_data
);
   import cle_pkg::*;

   logic [COUNT_W-1:0] ptr_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               load;
   logic               final_beat;

   assign rsp_empty  = !rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign final_beat = ptr_ff == (head.count - 1'b1);
   assign load       = head_valid && (!rsp_valid_ff || rsp_pop);
   assign head_pop   = load && final_beat;

   // Hold the output beat
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.out_byte     <= head.bytes[ptr_ff];
         rsp_ff.out_last     <= head.last && final_beat;
         rsp_ff.escape_error <= head.err;
      end
   end

   // Step through the beats of the head command
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            ptr_ff       <= final_beat ? '0 : ptr_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ptr_ff < head.count)
      else $error("beat pointer past command length");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.escape_error |-> rsp_ff.out_last)
      else $error("error beat not marked last");

endmodule

FILE: sv/c_literal_escape_stream.sv
// Escapes a raw text byte stream into C literal text.
// Input channel: req_data (byte and last flag) is taken at an edge with
// req_push high and req_full low. Result channel: while rsp_empty is low
// the oldest result beat is on rsp_data; it is taken at an edge with
// rsp_pop high. csr_write with csr_wdata sets the wrap-quotes bit.
// The front classifies one input beat per cycle, while req_full is low,
// against the tracked context and queues a command of 0 to 5 output
// bytes; the back plays each command out one beat per cycle, while the
// receiver takes them, through an output register. An input's result
// beats pass through the command queue and the output register. One
// input is taken per cycle while inputs expand to one byte and the
// receiver keeps up; an input of more bytes holds the back until all of
// them are out, and req_full rises once the command queue (QUEUE_DEPTH
// entries) fills. A stalled receiver holds the result beat and backs up
// through the queue to req_full. Reset clears the context to plain text,
// marks a text start, empties the queue and sets wrap quotes to on.
module c_literal_escape_stream #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cle_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cle_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_wdata
);
   import cle_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    q_empty;
   logic    head_pop;

   assign accept = req_push && !req_full;

   cle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .push      (cmd_push),
      .cmd       (cmd)
   );

   cle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (head_pop),
      .head      (head),
      .full      (req_full),
      .empty     (q_empty)
   );

   cle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: sim/tb_top.sv
module tb_top;
   import cle_pkg::*;

   // Escape contexts tracked by the predictor; code 7 is unused and acts as plain text
   typedef enum logic [2:0] {
      CTX_PLAIN     = 3'd0,
      CTX_PLAIN_BSL = 3'd1,
      CTX_STR       = 3'd2,
      CTX_STR_BSL   = 3'd3,
      CTX_CHR_OPEN  = 3'd4,
      CTX_CHR_BSL   = 3'd5,
      CTX_CHR_CLOSE = 3'd6
   } ctx_type;

   // One stimulus row; n_typed > 0 or err_typed carries a hand-written expectation
   typedef struct packed {
      req_type          req;
      logic [1:0]       n_typed;
      logic             err_typed;
      logic [2:0][7:0]  typed_bytes;
   } row_type;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic    csr_wdata = 1'b0;

   // Predictor state and the beats it still owes
   ctx_type    ctx_q        = CTX_PLAIN;
   bit         text_start_q = 1'b1;
   bit         wrap_q       = 1'b1;
   logic [7:0] esc_bytes[$];
   rsp_type    expected_beats[$];
   row_type    stim_rows[$];

   int mismatch_count = 0;
   int idle_cycles    = 0;
   bit tx_idle_on     = 1'b1;
   bit rx_idle_on     = 1'b1;
   bit hold_rsp       = 1'b0;

   c_literal_escape_stream u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Print one mismatch line and count it
   task automatic flag_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic logic [7:0] ctl_letter(input logic [7:0] c);
      case (c)
         8'h07: return "a";
         8'h08: return "b";
         8'h0C: return "f";
         8'h0A: return "n";
         8'h0D: return "r";
         8'h09: return "t";
         8'h0B: return "v";
         default: return NUL_CHAR;
      endcase
   endfunction

   function automatic bit is_simple_escape(input logic [7:0] c);
      return c == "a" || c == "b" || c == "f" || c == "n" || c == "r" ||
             c == "t" || c == "v" || c == SQ_CHAR || c == "?";
   endfunction

   task automatic put(input logic [7:0] b);
      if (esc_bytes.size() < 8) esc_bytes.push_back(b);
   endtask

   task automatic escape_plain(input logic [7:0] c, input bit last);
      logic [7:0] l;
      l = ctl_letter(c);
      ctx_q = CTX_PLAIN;
      if (l != NUL_CHAR) begin
         put(BSL_CHAR); put(l);
      end else if (c == BSL_CHAR) begin
         if (last) begin
            put(BSL_CHAR); put(BSL_CHAR);
         end else begin
            ctx_q = CTX_PLAIN_BSL;
         end
      end else if (c == DQ_CHAR) begin
         put(BSL_CHAR); put(DQ_CHAR);
         ctx_q = CTX_STR;
      end else if (c == SQ_CHAR) begin
         put(SQ_CHAR);
         ctx_q = CTX_CHR_OPEN;
      end else begin
         put(c);
      end
   endtask

   // Advance the escaper state by one input beat; queue the beats it produces
   task automatic predict_escape(input req_type r, output rsp_type beats[$]);
      logic [7:0] c;
      logic [7:0] l;
      bit         last;
      bit         err;
      int         n;
      rsp_type    beat;
      c    = r.in_byte;
      last = r.in_last;
      err  = 1'b0;
      beats.delete();
      esc_bytes.delete();
      if (text_start_q && wrap_q) put(DQ_CHAR);
      text_start_q = 1'b0;
      case (ctx_q)
         CTX_PLAIN_BSL: begin
            if (is_simple_escape(c)) begin
               put(BSL_CHAR); put(BSL_CHAR); put(c);
            end else if (c == DQ_CHAR) begin
               put(BSL_CHAR); put(BSL_CHAR); put(BSL_CHAR); put(DQ_CHAR);
            end else if (c == BSL_CHAR) begin
               put(BSL_CHAR); put(BSL_CHAR); put(BSL_CHAR); put(BSL_CHAR);
            end else begin
               put(c);
            end
            ctx_q = CTX_PLAIN;
         end
         CTX_STR: begin
            l = ctl_letter(c);
            if (l != NUL_CHAR) begin
               put(BSL_CHAR); put(l);
            end else if (c == BSL_CHAR) begin
               if (last) err = 1'b1;
               else ctx_q = CTX_STR_BSL;
            end else if (c == DQ_CHAR) begin
               // closing quote leaves the string instead of reopening one
               put(BSL_CHAR); put(DQ_CHAR);
               ctx_q = CTX_PLAIN;
            end else begin
               put(c);
            end
         end
         CTX_STR_BSL: begin
            put(BSL_CHAR); put(BSL_CHAR);
            if (is_simple_escape(c)) begin
               put(BSL_CHAR); put(c);
            end else if (c == DQ_CHAR) begin
               put(BSL_CHAR); put(DQ_CHAR);
            end else if (c == BSL_CHAR) begin
               put(BSL_CHAR); put(BSL_CHAR);
            end else begin
               put(c);
            end
            ctx_q = CTX_STR;
         end
         CTX_CHR_OPEN: begin
            if (c == BSL_CHAR) begin
               if (last) begin
                  put(BSL_CHAR); put(BSL_CHAR);
                  ctx_q = CTX_CHR_CLOSE;
               end else begin
                  ctx_q = CTX_CHR_BSL;
               end
            end else if (c == DQ_CHAR) begin
               put(BSL_CHAR); put(DQ_CHAR);
               ctx_q = CTX_CHR_CLOSE;
            end else if (c == SQ_CHAR) begin
               put(BSL_CHAR); put(SQ_CHAR);
               ctx_q = CTX_CHR_CLOSE;
            end else begin
               put(c);
               ctx_q = CTX_CHR_CLOSE;
            end
         end
         CTX_CHR_BSL: begin
            if (c == BSL_CHAR) begin
               put(BSL_CHAR); put(BSL_CHAR); put(BSL_CHAR); put(BSL_CHAR);
            end else if (c == DQ_CHAR) begin
               put(BSL_CHAR); put(DQ_CHAR);
            end else begin
               put(BSL_CHAR); put(BSL_CHAR); put(c);
            end
            ctx_q = CTX_CHR_CLOSE;
         end
         CTX_CHR_CLOSE: begin
            if (c == SQ_CHAR) begin
               put(SQ_CHAR);
               ctx_q = CTX_PLAIN;
            end else begin
               escape_plain(c, last);
            end
         end
         default: escape_plain(c, last);
      endcase

      if (err) begin
         // trailing backslash in a string: one error beat, no closing wrap quote
         ctx_q        = CTX_PLAIN;
         text_start_q = 1'b1;
         beat.out_byte     = NUL_CHAR;
         beat.out_last     = 1'b1;
         beat.escape_error = 1'b1;
         beats.push_back(beat);
      end else begin
         if (last) begin
            if (wrap_q) put(DQ_CHAR);
            ctx_q        = CTX_PLAIN;
            text_start_q = 1'b1;
         end
         n = (esc_bytes.size() > MAX_BEATS) ? MAX_BEATS : esc_bytes.size();
         for (int k = 0; k < n; k++) begin
            beat.out_byte     = esc_bytes[k];
            beat.out_last     = last && (k == n - 1);
            beat.escape_error = 1'b0;
            beats.push_back(beat);
         end
      end
   endtask

   task automatic add_row(input logic [7:0] b, input bit last, input int n = 0,
                          input logic [7:0] b0 = 8'h00, input logic [7:0] b1 = 8'h00,
                          input logic [7:0] b2 = 8'h00, input bit err = 1'b0);
      row_type row;
      row.req.in_byte   = b;
      row.req.in_last   = last;
      row.n_typed       = 2'(n);
      row.err_typed     = err;
      row.typed_bytes[0] = b0;
      row.typed_bytes[1] = b1;
      row.typed_bytes[2] = b2;
      stim_rows.push_back(row);
   endtask

   // Offer one beat, hold it until taken, then record what it should produce
   task automatic send_row(input row_type row);
      rsp_type beats[$];
      rsp_type beat;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= row.req;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_escape(row.req, beats);
      if (row.err_typed) begin
         beat.out_byte     = NUL_CHAR;
         beat.out_last     = 1'b1;
         beat.escape_error = 1'b1;
         expected_beats.push_back(beat);
      end else if (row.n_typed != 0) begin
         for (int k = 0; k < row.n_typed; k++) begin
            beat.out_byte     = row.typed_bytes[k];
            beat.out_last     = row.req.in_last && (k == row.n_typed - 1);
            beat.escape_error = 1'b0;
            expected_beats.push_back(beat);
         end
      end else begin
         foreach (beats[k]) expected_beats.push_back(beats[k]);
      end
   endtask

   // Hold the input, let everything drain, then write the wrap bit
   task automatic set_wrap(input bit value);
      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      wrap_q = value;
   endtask

   // Weighted byte choice: specials often, any byte value still reachable
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         4: return BSL_CHAR;
         5: return DQ_CHAR;
         6: return SQ_CHAR;
         7: return 8'($urandom_range(7, 13));
         8: begin
            case ($urandom_range(0, 7))
               0: return "a";
               1: return "b";
               2: return "f";
               3: return "n";
               4: return "r";
               5: return "t";
               6: return "v";
               default: return "?";
            endcase
         end
         9: return 8'($urandom_range(32, 126));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send whole texts of random length until about n_items beats went in
   task automatic run_texts(input int n_items);
      int      sent;
      int      len;
      row_type row;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            row = '0;
            row.req.in_byte = pick_byte();
            row.req.in_last = (k == len - 1);
            // often end a text on a backslash
            if (row.req.in_last && $urandom_range(0, 4) == 0) row.req.in_byte = BSL_CHAR;
            send_row(row);
            sent++;
         end
      end
   endtask

   // Stimulus: directed table, then random texts with wrap quotes off and on in turn
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_row("A", 1'b1, 3, DQ_CHAR, "A", DQ_CHAR);
      add_row(DQ_CHAR, 1'b0, 3, DQ_CHAR, BSL_CHAR, DQ_CHAR);
      add_row(BSL_CHAR, 1'b1, 0, 8'h00, 8'h00, 8'h00, 1'b1);
      add_row(8'h00, 1'b0);
      add_row(8'hFF, 1'b0);
      for (int c = 7; c <= 13; c++) add_row(8'(c), 1'b0);
      add_row(BSL_CHAR, 1'b0);
      add_row("n", 1'b0);
      add_row(BSL_CHAR, 1'b0);
      add_row(DQ_CHAR, 1'b0);
      add_row(BSL_CHAR, 1'b0);
      add_row("x", 1'b0);
      add_row(DQ_CHAR, 1'b0);
      add_row(BSL_CHAR, 1'b0);
      add_row("?", 1'b0);
      add_row(8'h0A, 1'b0);
      add_row(DQ_CHAR, 1'b0);
      add_row(SQ_CHAR, 1'b0);
      add_row(BSL_CHAR, 1'b0);
      add_row(SQ_CHAR, 1'b0);
      add_row("q", 1'b0);
      add_row(BSL_CHAR, 1'b1, 3, BSL_CHAR, BSL_CHAR, DQ_CHAR);
      foreach (stim_rows[i]) send_row(stim_rows[i]);

      set_wrap(1'b0);
      run_texts(30);

      set_wrap(1'b1);
      hold_rsp = 1'b1;
      run_texts(30);

      set_wrap(1'b0);
      run_texts(30);

      // final stretch runs without gaps on either side
      set_wrap(1'b1);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      run_texts(30);

      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Result side: pop with random gaps, one long hold, check each beat
   initial begin
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (rsp_empty === 1'b0) begin
            if (expected_beats.size() == 0) begin
               flag_mismatch("unexpected beat", rsp_data.out_byte, 8'h00);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  flag_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.out_last !== want.out_last)
                  flag_mismatch("out_last", 8'(rsp_data.out_last), 8'(want.out_last));
               if (rsp_data.escape_error !== want.escape_error)
                  flag_mismatch("escape_error", 8'(rsp_data.escape_error),
                                8'(want.escape_error));
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

FILE: c_literal_escape_stream.f
sv/cle_pkg.sv
sv/cle_front.sv
sv/cle_queue.sv
sv/cle_back.sv
sv/c_literal_escape_stream.sv
sim/tb_top.sv
